// ===== design/tsl_pkg.sv =====
package tsl_pkg;

	localparam int FRAC_BITS          = 8;
	localparam int MAX_TILES_PER_AXIS = 256;
	localparam int MAX_TILE_SIZE      = 4096;

	localparam int COORD_W = 28;
	localparam int INT_W   = COORD_W - FRAC_BITS;
	localparam int CNT_W   = 9;
	localparam int SIZE_W  = 13;
	localparam int IDX_W   = 8;
	localparam int CFG_W   = 13;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_TILE_COLS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_ROWS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_W    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_H    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_X   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_Y   = 3'd5;

	typedef struct packed {
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
	} point_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] edge_col;
		logic [IDX_W-1:0] edge_row;
		logic             edge_dir;
	} result_t;

	typedef struct packed {
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic               miss;
		logic               satx;
		logic               saty;
	} carry_t;

endpackage

// ===== design/tsl_div.sv =====
// quotient of num / den, assumed below 256; two quotient bits per stage, four stages
module tsl_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [tsl_pkg::INT_W-1:0]  num,
	input  logic [tsl_pkg::SIZE_W-1:0] den,
	output logic [tsl_pkg::IDX_W-1:0]  quo
);

	logic [20:0] rem_d [0:3];
	logic [7:0]  quo_d [0:3];
	logic [20:0] rem_s [1:4];
	logic [7:0]  quo_s [1:4];

	assign rem_d[0] = 21'(num);
	assign quo_d[0] = '0;

	for (genvar k = 0; k < 4; k++) begin : g_stage
		localparam int SH0 = 7 - 2 * k;
		localparam int SH1 = 6 - 2 * k;
		logic [20:0] sub_a, sub_b, rem_a, rem_b;
		logic [7:0]  quo_a, quo_b;

		if (k > 0) begin : g_link
			assign rem_d[k] = rem_s[k];
			assign quo_d[k] = quo_s[k];
		end

		always_comb begin
			sub_a = 21'(den) << SH0;
			sub_b = 21'(den) << SH1;
			rem_a = rem_d[k];
			quo_a = quo_d[k];
			if (rem_a >= sub_a) begin
				rem_a = rem_a - sub_a;
				quo_a[SH0] = 1'b1;
			end
			rem_b = rem_a;
			quo_b = quo_a;
			if (rem_b >= sub_b) begin
				rem_b = rem_b - sub_b;
				quo_b[SH1] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= rem_b;
				quo_s[k+1] <= quo_b;
			end
		end
	end

	assign quo = quo_s[4];

endmodule

// ===== design/tile_seam_locator_top.sv =====
// an accepted word is registered through stages 1 to 8 and then the output register before it appears on result
// throughput: one word per cycle; the whole pipeline holds while a valid result is stalled
// the column and row come from two 4-stage restoring dividers, 2 quotient bits per stage
// reset: valid bits cleared, registers back to 1 column, 1 row, size and pitch 256
module tile_seam_locator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          point_valid,
	output logic                          point_stall,
	input  tsl_pkg::point_t               point,
	output logic                          result_valid,
	input  logic                          result_stall,
	output tsl_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [tsl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsl_pkg::CFG_W-1:0]     cfg_data
);

	logic [tsl_pkg::CNT_W-1:0]  tile_cols_q, tile_rows_q;
	logic [tsl_pkg::SIZE_W-1:0] tile_w_q, tile_h_q, pitch_x_q, pitch_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_cols_q <= 9'd1;
			tile_rows_q <= 9'd1;
			tile_w_q    <= 13'd256;
			tile_h_q    <= 13'd256;
			pitch_x_q   <= 13'd256;
			pitch_y_q   <= 13'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsl_pkg::CFG_TILE_COLS: tile_cols_q <= cfg_data[8:0];
				tsl_pkg::CFG_TILE_ROWS: tile_rows_q <= cfg_data[8:0];
				tsl_pkg::CFG_TILE_W:    tile_w_q    <= cfg_data;
				tsl_pkg::CFG_TILE_H:    tile_h_q    <= cfg_data;
				tsl_pkg::CFG_PITCH_X:   pitch_x_q   <= cfg_data;
				tsl_pkg::CFG_PITCH_Y:   pitch_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturated settings
	logic [8:0]  cols, rows;
	logic [12:0] tw, th, sx, sy;
	logic [7:0]  col_max, row_max;
	logic        ovx_pos, ovy_pos;
	logic [11:0] ovx, ovy;
	logic [12:0] ovx_full, ovy_full;

	assign cols = (tile_cols_q > 9'(tsl_pkg::MAX_TILES_PER_AXIS)) ?
		9'(tsl_pkg::MAX_TILES_PER_AXIS) : tile_cols_q;
	assign rows = (tile_rows_q > 9'(tsl_pkg::MAX_TILES_PER_AXIS)) ?
		9'(tsl_pkg::MAX_TILES_PER_AXIS) : tile_rows_q;
	assign tw = (tile_w_q > 13'(tsl_pkg::MAX_TILE_SIZE)) ? 13'(tsl_pkg::MAX_TILE_SIZE) : tile_w_q;
	assign th = (tile_h_q > 13'(tsl_pkg::MAX_TILE_SIZE)) ? 13'(tsl_pkg::MAX_TILE_SIZE) : tile_h_q;
	assign sx = (pitch_x_q > 13'(tsl_pkg::MAX_TILE_SIZE)) ? 13'(tsl_pkg::MAX_TILE_SIZE) : pitch_x_q;
	assign sy = (pitch_y_q > 13'(tsl_pkg::MAX_TILE_SIZE)) ? 13'(tsl_pkg::MAX_TILE_SIZE) : pitch_y_q;
	assign col_max  = 8'(cols - 9'd1);
	assign row_max  = 8'(rows - 9'd1);
	assign ovx_pos  = tw > sx;
	assign ovy_pos  = th > sy;
	assign ovx_full = tw - sx;
	assign ovy_full = th - sy;
	assign ovx      = ovx_full[11:0];
	assign ovy      = ovy_full[11:0];

	logic adv;
	assign adv         = !result_valid || !result_stall;
	assign point_stall = !adv;

	// stage 1: map extent and quotient overflow
	logic [20:0] ext_x, ext_y;
	logic [19:0] nx, ny;
	tsl_pkg::carry_t carry_s [1:5];
	logic [1:8] v_s;

	assign nx    = point.point_x[27:8];
	assign ny    = point.point_y[27:8];
	assign ext_x = 21'(col_max) * 21'(sx) + 21'(tw);
	assign ext_y = 21'(row_max) * 21'(sy) + 21'(th);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {point_valid, v_s[1:7]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			carry_s[1].px   <= point.point_x;
			carry_s[1].py   <= point.point_y;
			carry_s[1].miss <= (cols == 9'd0) || (rows == 9'd0) || (sx == 13'd0) ||
				(sy == 13'd0) || (21'(nx) >= ext_x) || (21'(ny) >= ext_y);
			carry_s[1].satx <= 21'(nx) >= {sx, 8'd0};
			carry_s[1].saty <= 21'(ny) >= {sy, 8'd0};
			for (int i = 2; i <= 5; i++) begin
				carry_s[i] <= carry_s[i-1];
			end
		end
	end

	// stages 2 to 5: division by the pitch
	logic [7:0] qx, qy;

	tsl_div u_div_x (
		.clk (clk),
		.en  (adv),
		.num (carry_s[1].px[27:8]),
		.den (sx),
		.quo (qx)
	);

	tsl_div u_div_y (
		.clk (clk),
		.en  (adv),
		.num (carry_s[1].py[27:8]),
		.den (sy),
		.quo (qy)
	);

	// stage 6: clamp and band starts
	logic [7:0]  col_c, row_c;
	logic [7:0]  col_s6, row_s6;
	logic [20:0] vstart_s6, hstart_s6;
	logic [27:0] px_s6, py_s6;
	logic        miss_s6;

	assign col_c = (carry_s[5].satx || qx > col_max) ? col_max : qx;
	assign row_c = (carry_s[5].saty || qy > row_max) ? row_max : qy;

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s6    <= col_c;
			row_s6    <= row_c;
			vstart_s6 <= 21'(col_c) * 21'(sx);
			hstart_s6 <= 21'(row_c) * 21'(sy);
			px_s6     <= carry_s[5].px;
			py_s6     <= carry_s[5].py;
			miss_s6   <= carry_s[5].miss;
		end
	end

	// stage 7: band tests and doubled distances from band centres
	logic [20:0] vend, hend;
	logic [30:0] av, bv, ah, bh;
	logic [30:0] dv_s7, dh_s7;
	logic        in_v_s7, in_h_s7, miss_s7;
	logic [7:0]  col_s7, row_s7;

	assign vend = vstart_s6 + 21'(ovx);
	assign hend = hstart_s6 + 21'(ovy);
	assign av   = {2'd0, px_s6, 1'b0};
	assign ah   = {2'd0, py_s6, 1'b0};
	assign bv   = {1'b0, vstart_s6, 9'd0} + {11'd0, ovx, 8'd0};
	assign bh   = {1'b0, hstart_s6, 9'd0} + {11'd0, ovy, 8'd0};

	always_ff @(posedge clk) begin
		if (adv) begin
			in_v_s7 <= (col_s6 != 8'd0) && ovx_pos && ({1'b0, px_s6} < {vend, 8'd0});
			in_h_s7 <= (row_s6 != 8'd0) && ovy_pos && ({1'b0, py_s6} < {hend, 8'd0});
			dv_s7   <= (av >= bv) ? av - bv : bv - av;
			dh_s7   <= (ah >= bh) ? ah - bh : bh - ah;
			col_s7  <= col_s6;
			row_s7  <= row_s6;
			miss_s7 <= miss_s6;
		end
	end

	// stage 8: cross products
	logic [42:0] pv_s8, ph_s8;
	logic        in_v_s8, in_h_s8, miss_s8;
	logic [7:0]  col_s8, row_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			pv_s8   <= 43'(dv_s7) * 43'(ovy);
			ph_s8   <= 43'(dh_s7) * 43'(ovx);
			in_v_s8 <= in_v_s7;
			in_h_s8 <= in_h_s7;
			col_s8  <= col_s7;
			row_s8  <= row_s7;
			miss_s8 <= miss_s7;
		end
	end

	// output register
	logic             pick_v, hit;
	tsl_pkg::result_t res_d, result_q;

	assign pick_v = (in_v_s8 && in_h_s8) ? (pv_s8 <= ph_s8) : in_v_s8;
	assign hit    = !miss_s8 && (in_v_s8 || in_h_s8);

	always_comb begin
		res_d = '0;
		if (hit) begin
			res_d.found = 1'b1;
			if (pick_v) begin
				res_d.edge_col = col_s8 - 8'd1;
				res_d.edge_row = row_s8;
				res_d.edge_dir = 1'b0;
			end else begin
				res_d.edge_col = col_s8;
				res_d.edge_row = row_s8 - 8'd1;
				res_d.edge_dir = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= v_s[8];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= res_d;
		end
	end

	assign result = result_q;

endmodule
